// ----- design/cit_pkg.sv -----
// Shared types and constants for the chunked install transaction block.
// Holds the command and status codes, the phase type and the field widths.
// No dependencies.
package cit_pkg;

    localparam int unsigned MAX_APP_ID_BYTES = 64;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned BYTES_W = 32;
    localparam int unsigned CHUNK_W = 16;
    localparam int unsigned ALEN_W  = 8;
    localparam int unsigned CRC_W   = 32;

    localparam int unsigned IN_DATA_W  = 160;
    localparam int unsigned OUT_DATA_W = 136;

    typedef enum logic [1:0] {
        ACT_BEGIN  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_COMMIT = 2'd2,
        ACT_ABORT  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_ACCEPTED    = 4'd0,
        ST_BUSY        = 4'd1,
        ST_INVALID     = 4'd2,
        ST_MISMATCH    = 4'd3,
        ST_TOO_LARGE   = 4'd4,
        ST_INCOMPLETE  = 4'd5,
        ST_STORE_REJ   = 4'd6,
        ST_INTEGRITY   = 4'd7,
        ST_COMMIT_FAIL = 4'd8,
        ST_ABORTED     = 4'd9,
        ST_NONE        = 4'd10
    } t_status;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_RECV = 1'b1
    } t_phase;

    typedef enum logic {
        CFG_MAX_BUNDLE = 1'b0,
        CFG_MAX_CHUNK  = 1'b1
    } t_cfg_reg;

    localparam logic [BYTES_W-1:0] MAX_BUNDLE_RESET = 32'd1048576;
    localparam logic [CHUNK_W-1:0] MAX_CHUNK_RESET  = 16'd4096;

endpackage

// ----- design/chunked_install_transaction_fsm.sv -----
// Receive-side control of a chunked bundle-install transaction.
// Depends on cit_pkg for codes, phase type and widths.
//
// One command transaction in, one status transaction out. Each command is
// checked against the held transaction state (id, declared total, running byte
// count) and the programmed limits combinationally, and its result lands in an
// output register; a new command is taken every cycle as long as the output
// register is empty or being drained in the same cycle, so the block sustains
// one command per clock. The discard flag in the result tells the store to
// drop staged data after a store failure, an integrity failure or an abort.
// Limits are to be written through the config port only while no command is
// in flight; the block itself does not enforce this.
module chunked_install_transaction_fsm (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write port
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    // command stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // low to high: txn_id, app_id_length, app_id_has_nul, total_bytes,
    // bundle_checksum, downgrade_ok, chunk_offset, chunk_size, store_ok,
    // verify_ok, zero pad
    input  logic [cit_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // low to high: action
    input  logic [1:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // low to high: status, phase_out, txn_id_out, received_out, total_out,
    // stage_discard, checksum_out, downgrade_out, zero pad
    output logic [cit_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // config registers
    logic [cit_pkg::BYTES_W-1:0] r_max_bundle;
    logic [cit_pkg::CHUNK_W-1:0] r_max_chunk;

    // transaction state
    cit_pkg::t_phase             r_phase, n_phase;
    logic [cit_pkg::ID_W-1:0]    r_txn_id, n_txn_id;
    logic [cit_pkg::BYTES_W-1:0] r_total, n_total;
    logic [cit_pkg::CRC_W-1:0]   r_crc, n_crc;
    logic                        r_down, n_down;
    logic [cit_pkg::BYTES_W-1:0] r_count, n_count;

    // result register
    logic                           r_out_valid;
    logic [cit_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    // unpacked command fields
    cit_pkg::t_action            in_action;
    logic [cit_pkg::ID_W-1:0]    in_txn_id;
    logic [cit_pkg::ALEN_W-1:0]  in_alen;
    logic                        in_has_nul;
    logic [cit_pkg::BYTES_W-1:0] in_total;
    logic [cit_pkg::CRC_W-1:0]   in_crc;
    logic                        in_down;
    logic [cit_pkg::BYTES_W-1:0] in_offset;
    logic [cit_pkg::CHUNK_W-1:0] in_size;
    logic                        in_store_ok;
    logic                        in_verify_ok;

    logic                        accept;
    logic                        clear_txn;
    logic                        commit_done;
    logic                        strobe;
    cit_pkg::t_status            status;
    logic [cit_pkg::BYTES_W-1:0] remaining;
    logic                        begin_bad;
    logic                        chunk_bad;
    logic                        id_match;

    // report fields
    logic                        rep_phase;
    logic [cit_pkg::ID_W-1:0]    rep_txn_id;
    logic [cit_pkg::BYTES_W-1:0] rep_count;
    logic [cit_pkg::BYTES_W-1:0] rep_total;
    logic [cit_pkg::CRC_W-1:0]   rep_crc;
    logic                        rep_down;

    assign in_action    = cit_pkg::t_action'(s_axis_tuser);
    assign in_txn_id    = s_axis_tdata[31:0];
    assign in_alen      = s_axis_tdata[39:32];
    assign in_has_nul   = s_axis_tdata[40];
    assign in_total     = s_axis_tdata[72:41];
    assign in_crc       = s_axis_tdata[104:73];
    assign in_down      = s_axis_tdata[105];
    assign in_offset    = s_axis_tdata[137:106];
    assign in_size      = s_axis_tdata[153:138];
    assign in_store_ok  = s_axis_tdata[154];
    assign in_verify_ok = s_axis_tdata[155];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign remaining = r_total - r_count;
    assign id_match  = (in_txn_id == r_txn_id);
    assign begin_bad = (in_txn_id == '0) || (in_alen == '0)
                     || (in_alen > cit_pkg::ALEN_W'(cit_pkg::MAX_APP_ID_BYTES))
                     || in_has_nul || (in_total == '0) || (r_max_bundle == '0)
                     || (in_total > r_max_bundle);
    assign chunk_bad = (in_size == '0) || (in_size > r_max_chunk)
                     || ({{(cit_pkg::BYTES_W-cit_pkg::CHUNK_W){1'b0}}, in_size} > remaining);

    // decide status, strobe and whether the transaction is dropped
    always_comb begin
        status      = cit_pkg::ST_ACCEPTED;
        strobe      = 1'b0;
        clear_txn   = 1'b0;
        commit_done = 1'b0;
        if (in_action == cit_pkg::ACT_BEGIN) begin
            if (r_phase == cit_pkg::PH_RECV) begin
                status = cit_pkg::ST_BUSY;
            end else if (begin_bad) begin
                status = cit_pkg::ST_INVALID;
            end else if (!in_store_ok) begin
                status = cit_pkg::ST_STORE_REJ;
            end
        end else if (r_phase == cit_pkg::PH_IDLE) begin
            status = cit_pkg::ST_NONE;
        end else begin
            case (in_action)
                cit_pkg::ACT_APPEND: begin
                    if (!id_match || in_offset != r_count) begin
                        status = cit_pkg::ST_MISMATCH;
                    end else if (chunk_bad) begin
                        status = cit_pkg::ST_TOO_LARGE;
                    end else if (!in_store_ok) begin
                        status    = cit_pkg::ST_STORE_REJ;
                        strobe    = 1'b1;
                        clear_txn = 1'b1;
                    end
                end
                cit_pkg::ACT_COMMIT: begin
                    if (!id_match) begin
                        status = cit_pkg::ST_MISMATCH;
                    end else if (r_count != r_total) begin
                        status = cit_pkg::ST_INCOMPLETE;
                    end else if (!in_verify_ok) begin
                        status    = cit_pkg::ST_INTEGRITY;
                        strobe    = 1'b1;
                        clear_txn = 1'b1;
                    end else if (!in_store_ok) begin
                        status    = cit_pkg::ST_COMMIT_FAIL;
                        strobe    = 1'b1;
                        clear_txn = 1'b1;
                    end else begin
                        clear_txn   = 1'b1;
                        commit_done = 1'b1;
                    end
                end
                cit_pkg::ACT_ABORT: begin
                    if (!id_match) begin
                        status = cit_pkg::ST_MISMATCH;
                    end else begin
                        status    = cit_pkg::ST_ABORTED;
                        strobe    = 1'b1;
                        clear_txn = 1'b1;
                    end
                end
                default: begin
                    status = cit_pkg::ST_NONE;
                end
            endcase
        end
    end

    // next transaction state
    always_comb begin
        n_phase  = r_phase;
        n_txn_id = r_txn_id;
        n_total  = r_total;
        n_crc    = r_crc;
        n_down   = r_down;
        n_count  = r_count;
        if (clear_txn) begin
            n_phase  = cit_pkg::PH_IDLE;
            n_txn_id = '0;
            n_total  = '0;
            n_crc    = '0;
            n_down   = 1'b0;
            n_count  = '0;
        end else if (status == cit_pkg::ST_ACCEPTED) begin
            if (in_action == cit_pkg::ACT_BEGIN) begin
                n_phase  = cit_pkg::PH_RECV;
                n_txn_id = in_txn_id;
                n_total  = in_total;
                n_crc    = in_crc;
                n_down   = in_down;
                n_count  = '0;
            end else begin
                n_count = r_count
                        + {{(cit_pkg::BYTES_W-cit_pkg::CHUNK_W){1'b0}}, in_size};
            end
        end
    end

    // result: values after the update, or before it when the command drops the transaction
    always_comb begin
        if (clear_txn) begin
            rep_phase  = commit_done ? 1'b0 : r_phase;
            rep_txn_id = r_txn_id;
            rep_count  = r_count;
            rep_total  = r_total;
            rep_crc    = r_crc;
            rep_down   = r_down;
        end else begin
            rep_phase  = n_phase;
            rep_txn_id = n_txn_id;
            rep_count  = n_count;
            rep_total  = n_total;
            rep_crc    = n_crc;
            rep_down   = n_down;
        end
        n_out_data = {1'b0, rep_down, rep_crc, strobe, rep_total, rep_count,
                      rep_txn_id, rep_phase, status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bundle <= cit_pkg::MAX_BUNDLE_RESET;
            r_max_chunk  <= cit_pkg::MAX_CHUNK_RESET;
        end else if (i_cfg_we) begin
            case (cit_pkg::t_cfg_reg'(i_cfg_idx))
                cit_pkg::CFG_MAX_BUNDLE: r_max_bundle <= i_cfg_wdata;
                cit_pkg::CFG_MAX_CHUNK:  r_max_chunk  <= i_cfg_wdata[cit_pkg::CHUNK_W-1:0];
                default: begin
                    r_max_bundle <= r_max_bundle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cit_pkg::PH_IDLE;
            r_txn_id <= '0;
            r_total  <= '0;
            r_crc    <= '0;
            r_down   <= 1'b0;
            r_count  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_txn_id <= n_txn_id;
            r_total  <= n_total;
            r_crc    <= n_crc;
            r_down   <= n_down;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTH
    // idle always holds a cleared transaction
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cit_pkg::PH_IDLE |-> (r_txn_id == '0 && r_count == '0 && r_total == '0))
        else $error("idle phase with stale transaction state");

    // running count never passes the declared total
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_total)
        else $error("byte count exceeds declared total");

    // abort strobe only with a discarding status
    a_strobe_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[101]) |->
            (r_out_data[3:0] == cit_pkg::ST_STORE_REJ
             || r_out_data[3:0] == cit_pkg::ST_INTEGRITY
             || r_out_data[3:0] == cit_pkg::ST_COMMIT_FAIL
             || r_out_data[3:0] == cit_pkg::ST_ABORTED))
        else $error("abort strobe with non-discarding status");

    // a dropped transaction leaves the block idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && strobe) |=> r_phase == cit_pkg::PH_IDLE)
        else $error("transaction still active after abort strobe");
`endif

endmodule

// ----- sim/tb_chunked_install_transaction_fsm.sv -----
// Self-checking testbench for chunked_install_transaction_fsm.
// Drives begin/append/commit/abort command transactions, predicts each status in step
// with the block and checks it field by field. Depends on cit_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_chunked_install_transaction_fsm;
    import cit_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    typedef struct {
        t_action     act;
        logic [31:0] id;
        logic [7:0]  alen;
        logic        nul;
        logic [31:0] total;
        logic [31:0] crc;
        logic        down;
        logic [31:0] ofs;
        logic [15:0] size;
        logic        store_ok;
        logic        verify_ok;
    } t_command;

    typedef struct {
        t_status     status;
        t_phase      phase;
        logic [31:0] id;
        logic [31:0] received;
        logic [31:0] total;
        logic        strobe;
        logic [31:0] crc;
        logic        down;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = 1'b0;
    logic [31:0]           i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // low to high: txn_id, app_id_length, app_id_has_nul, total_bytes, bundle_checksum,
    // downgrade_ok, chunk_offset, chunk_size, store_ok, verify_ok, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // low to high: action
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // low to high: status, phase_out, txn_id_out, received_out, total_out,
    // stage_discard, checksum_out, downgrade_out, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    chunked_install_transaction_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Transaction tracker state and limits as the block should hold them
    t_phase      rx_phase = PH_IDLE;
    logic [31:0] held_id = '0;
    logic [31:0] held_total = '0;
    logic [31:0] held_crc = '0;
    logic        held_down = 1'b0;
    logic [31:0] rx_bytes = '0;
    logic [31:0] lim_bundle = MAX_BUNDLE_RESET;
    logic [15:0] lim_chunk = MAX_CHUNK_RESET;

    t_command    pending_cmds[$];
    t_result     predicted_results[$];
    t_command    cur_cmd;
    logic        cmd_fire = 1'b0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    logic [31:0] last_gen_id = 32'd1;

    int unsigned cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_commands = 0;
    int unsigned n_results = 0;
    int unsigned n_commits = 0;
    int unsigned n_strobes = 0;

    // Advance the tracker by one command and return the status it reports
    function automatic t_result apply_command(t_command c);
        t_result r;
        t_status st;
        logic    strobe;
        logic    clear;
        logic    committed;
        st = ST_ACCEPTED;
        strobe = 1'b0;
        clear = 1'b0;
        committed = 1'b0;
        if (c.act == ACT_BEGIN) begin
            if (rx_phase == PH_RECV) begin
                st = ST_BUSY;
            end else if (c.id == 0 || c.alen == 0 || c.alen > MAX_APP_ID_BYTES || c.nul ||
                         c.total == 0 || lim_bundle == 0 || c.total > lim_bundle) begin
                st = ST_INVALID;
            end else if (!c.store_ok) begin
                st = ST_STORE_REJ;
            end else begin
                rx_phase = PH_RECV;
                held_id = c.id;
                held_total = c.total;
                held_crc = c.crc;
                held_down = c.down;
                rx_bytes = '0;
            end
        end else if (rx_phase == PH_IDLE) begin
            st = ST_NONE;
        end else if (c.id != held_id) begin
            st = ST_MISMATCH;
        end else if (c.act == ACT_APPEND) begin
            if (c.ofs != rx_bytes) begin
                st = ST_MISMATCH;
            end else if (c.size == 0 || c.size > lim_chunk ||
                         32'(c.size) > held_total - rx_bytes) begin
                st = ST_TOO_LARGE;
            end else if (!c.store_ok) begin
                st = ST_STORE_REJ;
                strobe = 1'b1;
                clear = 1'b1;
            end else begin
                rx_bytes = rx_bytes + 32'(c.size);
            end
        end else if (c.act == ACT_COMMIT) begin
            if (rx_bytes != held_total) begin
                st = ST_INCOMPLETE;
            end else if (!c.verify_ok) begin
                st = ST_INTEGRITY;
                strobe = 1'b1;
                clear = 1'b1;
            end else if (!c.store_ok) begin
                st = ST_COMMIT_FAIL;
                strobe = 1'b1;
                clear = 1'b1;
            end else begin
                committed = 1'b1;
                clear = 1'b1;
            end
        end else begin
            st = ST_ABORTED;
            strobe = 1'b1;
            clear = 1'b1;
        end
        r.status = st;
        r.phase = committed ? PH_IDLE : rx_phase;
        r.id = held_id;
        r.received = rx_bytes;
        r.total = held_total;
        r.strobe = strobe;
        r.crc = held_crc;
        r.down = held_down;
        if (committed) n_commits++;
        if (strobe) n_strobes++;
        if (clear) begin
            rx_phase = PH_IDLE;
            held_id = '0;
            held_total = '0;
            held_crc = '0;
            held_down = 1'b0;
            rx_bytes = '0;
        end
        return r;
    endfunction

    function automatic bit field_differs(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v === got_v) return 1'b0;
        if (mismatch_count < SHOWN_MISMATCHES)
            $display("MISMATCH %s: expected 0x%08h, got 0x%08h (result %0d)",
                     name, exp_v, got_v, n_results);
        return 1'b1;
    endfunction

    // Sender: present the next queued command once the previous one is taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || cmd_fire) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                cur_cmd = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cur_cmd.act;
                s_axis_tdata <= {4'b0, cur_cmd.verify_ok, cur_cmd.store_ok, cur_cmd.size,
                                 cur_cmd.ofs, cur_cmd.down, cur_cmd.crc, cur_cmd.total,
                                 cur_cmd.nul, cur_cmd.alen, cur_cmd.id};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // Monitor: predict on each accepted command, check each delivered status
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got_r;
        bit      bad;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, predicted_results.size());
            $display("chunked_install_transaction_fsm test failed");
            $finish;
        end
        cmd_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predicted_results.push_back(apply_command(cur_cmd));
            n_commands++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.status = t_status'(m_axis_tdata[3:0]);
            got_r.phase = t_phase'(m_axis_tdata[4]);
            got_r.id = m_axis_tdata[36:5];
            got_r.received = m_axis_tdata[68:37];
            got_r.total = m_axis_tdata[100:69];
            got_r.strobe = m_axis_tdata[101];
            got_r.crc = m_axis_tdata[133:102];
            got_r.down = m_axis_tdata[134];
            if (predicted_results.size() == 0) begin
                if (mismatch_count < SHOWN_MISMATCHES)
                    $display("MISMATCH unexpected result, status %0d", got_r.status);
                mismatch_count++;
            end else begin
                exp_r = predicted_results.pop_front();
                bad = 1'b0;
                bad |= field_differs("status", 32'(exp_r.status), 32'(got_r.status));
                bad |= field_differs("phase_out", 32'(exp_r.phase), 32'(got_r.phase));
                bad |= field_differs("txn_id_out", exp_r.id, got_r.id);
                bad |= field_differs("received_out", exp_r.received, got_r.received);
                bad |= field_differs("total_out", exp_r.total, got_r.total);
                bad |= field_differs("stage_discard", 32'(exp_r.strobe), 32'(got_r.strobe));
                bad |= field_differs("checksum_out", exp_r.crc, got_r.crc);
                bad |= field_differs("downgrade_out", 32'(exp_r.down), 32'(got_r.down));
                if (bad) mismatch_count++;
            end
            n_results++;
        end
    end

    function automatic t_command random_command();
        t_command c;
        c.act = t_action'($urandom_range(0, 3));
        c.id = $urandom;
        c.alen = 8'($urandom);
        c.nul = 1'($urandom);
        c.total = $urandom;
        c.crc = $urandom;
        c.down = 1'($urandom);
        c.ofs = $urandom;
        c.size = 16'($urandom);
        c.store_ok = 1'($urandom);
        c.verify_ok = 1'($urandom);
        return c;
    endfunction

    // Fields a command does not use stay random: the block must ignore them
    function automatic t_command cmd_begin(logic [31:0] id, logic [7:0] alen,
                                           logic [31:0] total, logic ok);
        t_command c;
        c = random_command();
        c.act = ACT_BEGIN;
        c.id = id;
        c.alen = alen;
        c.nul = 1'b0;
        c.total = total;
        c.store_ok = ok;
        return c;
    endfunction

    function automatic t_command cmd_append(logic [31:0] id, logic [31:0] ofs,
                                            logic [15:0] size, logic ok);
        t_command c;
        c = random_command();
        c.act = ACT_APPEND;
        c.id = id;
        c.ofs = ofs;
        c.size = size;
        c.store_ok = ok;
        return c;
    endfunction

    function automatic t_command cmd_finish(t_action act, logic [31:0] id, logic store_ok,
                                            logic verify_ok);
        t_command c;
        c = random_command();
        c.act = act;
        c.id = id;
        c.store_ok = store_ok;
        c.verify_ok = verify_ok;
        return c;
    endfunction

    task automatic write_limit(t_cfg_reg idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_BUNDLE) lim_bundle = val;
        else lim_chunk = val[15:0];
    endtask

    // Hold until every queued command is taken and every status has come back
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_cmds.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly well-formed install sessions with random content, some noise and breakage
    task automatic queue_traffic(int unsigned n);
        int unsigned pushed;
        int unsigned r;
        int unsigned room;
        int unsigned sz;
        t_command    c;
        logic [31:0] id;
        logic [31:0] total;
        logic [31:0] cap;
        logic [31:0] done;
        // drop any session left open by the previous batch
        pending_cmds.push_back(cmd_finish(ACT_ABORT, last_gen_id, 1'b1, 1'b1));
        pushed = 1;
        while (pushed < n) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                pending_cmds.push_back(random_command());
                pushed++;
            end else begin
                id = $urandom;
                if (id == 0) id = 1;
                last_gen_id = id;
                if (lim_bundle == 0) begin
                    total = $urandom_range(1, 1000);
                end else begin
                    cap = lim_bundle;
                    if (lim_chunk == 0) begin
                        if (cap > 100) cap = 100;
                    end else if (cap > 6 * lim_chunk) begin
                        cap = 6 * lim_chunk;
                    end
                    total = ($urandom_range(0, 9) == 0) ? cap : $urandom_range(1, cap);
                end
                c = cmd_begin(id, 8'($urandom_range(1, MAX_APP_ID_BYTES)), total,
                              $urandom_range(0, 19) != 0);
                if ($urandom_range(0, 9) == 0) begin
                    c.alen = 8'($urandom);
                    c.nul = 1'($urandom);
                end
                pending_cmds.push_back(c);
                pushed++;
                done = 0;
                while (done < total && pushed < n) begin
                    room = (lim_chunk == 0) ? 50 :
                           ((total - done < lim_chunk) ? total - done : lim_chunk);
                    sz = $urandom_range(1, room);
                    c = cmd_append(id, done, 16'(sz), $urandom_range(0, 29) != 0);
                    r = $urandom_range(0, 19);
                    if (r == 0) c.ofs = ($urandom_range(0, 1) != 0) ? $urandom
                                                                   : done + 1;
                    else if (r == 1) c.size = (room < 16'hFFFF) ? 16'(room + 1) : 16'd0;
                    else if (r == 2) c.id = id ^ (32'd1 << $urandom_range(0, 31));
                    else done = done + sz;
                    pending_cmds.push_back(c);
                    pushed++;
                end
                if (pushed < n) begin
                    r = $urandom_range(0, 9);
                    if (r < 7) begin
                        c = cmd_finish(ACT_COMMIT, id, $urandom_range(0, 19) != 0,
                                       $urandom_range(0, 19) != 0);
                    end else if (r < 9) begin
                        c = cmd_finish(ACT_ABORT, id, 1'($urandom), 1'($urandom));
                    end else begin
                        c = cmd_finish(ACT_COMMIT, id ^ 32'h0000_8000, 1'b1, 1'b1);
                    end
                    pending_cmds.push_back(c);
                    pushed++;
                    // close sessions the commit may have left open
                    if (r == 9 || lim_chunk == 0 || $urandom_range(0, 2) == 0) begin
                        pending_cmds.push_back(cmd_finish(ACT_ABORT, id, 1'b1, 1'b1));
                        pushed++;
                    end
                end
            end
        end
    endtask

    task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
    endtask

    initial begin
        t_command c;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(7, 82);

        // Directed pass at the reset limits (bundle 1 MiB, chunk 4 KiB)
        pending_cmds.push_back(cmd_append(5, 0, 10, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_COMMIT, 5, 1'b1, 1'b1));
        pending_cmds.push_back(cmd_begin(0, 8, 100, 1'b1));
        pending_cmds.push_back(cmd_begin(5, 0, 100, 1'b1));
        pending_cmds.push_back(cmd_begin(5, 8'(MAX_APP_ID_BYTES + 1), 100, 1'b1));
        c = cmd_begin(5, 8, 100, 1'b1);
        c.nul = 1'b1;
        pending_cmds.push_back(c);
        pending_cmds.push_back(cmd_begin(5, 8, 0, 1'b1));
        pending_cmds.push_back(cmd_begin(5, 8, MAX_BUNDLE_RESET + 1, 1'b1));
        pending_cmds.push_back(cmd_begin(5, 8'(MAX_APP_ID_BYTES), 100, 1'b0));
        c = cmd_begin(32'hFFFF_FFFF, 8'(MAX_APP_ID_BYTES), MAX_BUNDLE_RESET, 1'b1);
        c.crc = 32'hFFFF_FFFF;
        c.down = 1'b1;
        pending_cmds.push_back(c);
        pending_cmds.push_back(cmd_begin(5, 8, 100, 1'b1));
        pending_cmds.push_back(cmd_append(32'hFFFF_FFFE, 0, 16, 1'b1));
        pending_cmds.push_back(cmd_append(32'hFFFF_FFFF, 1, 16, 1'b1));
        pending_cmds.push_back(cmd_append(32'hFFFF_FFFF, 0, 0, 1'b1));
        pending_cmds.push_back(cmd_append(32'hFFFF_FFFF, 0, 16'(MAX_CHUNK_RESET + 1), 1'b1));
        pending_cmds.push_back(cmd_append(32'hFFFF_FFFF, 0, MAX_CHUNK_RESET, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_COMMIT, 32'hFFFF_FFFF, 1'b1, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_ABORT, 0, 1'b1, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_ABORT, 32'hFFFF_FFFF, 1'b1, 1'b1));
        c = cmd_begin(7, 1, 5000, 1'b1);
        c.crc = '0;
        c.down = 1'b0;
        pending_cmds.push_back(c);
        pending_cmds.push_back(cmd_append(7, 0, 4096, 1'b1));
        pending_cmds.push_back(cmd_append(7, 4096, 905, 1'b1));
        pending_cmds.push_back(cmd_append(7, 4096, 904, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_COMMIT, 7, 1'b1, 1'b1));
        pending_cmds.push_back(cmd_begin(9, 1, 10, 1'b1));
        pending_cmds.push_back(cmd_append(9, 0, 10, 1'b0));
        pending_cmds.push_back(cmd_begin(9, 2, 1, 1'b1));
        pending_cmds.push_back(cmd_append(9, 0, 1, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_COMMIT, 9, 1'b1, 1'b0));
        pending_cmds.push_back(cmd_begin(3, 2, 1, 1'b1));
        pending_cmds.push_back(cmd_append(3, 0, 1, 1'b1));
        pending_cmds.push_back(cmd_finish(ACT_COMMIT, 3, 1'b0, 1'b1));
        wait_drained();

        // Small limits; pause mid-batch until every status is back
        write_limit(CFG_MAX_BUNDLE, 32'd300);
        write_limit(CFG_MAX_CHUNK, 32'd64);
        queue_traffic(150);
        wait_drained();
        queue_traffic(150);
        wait_drained();

        write_limit(CFG_MAX_BUNDLE, 32'hFFFF_FFFF);
        write_limit(CFG_MAX_CHUNK, 32'h0000_FFFF);
        queue_traffic(300);
        wait_drained();

        set_idle(82, 7);
        write_limit(CFG_MAX_BUNDLE, 32'd1);
        write_limit(CFG_MAX_CHUNK, 32'd1);
        queue_traffic(300);
        wait_drained();

        // Zero limits: every begin and every chunk is refused
        write_limit(CFG_MAX_BUNDLE, 32'd0);
        write_limit(CFG_MAX_CHUNK, 32'd0);
        queue_traffic(150);
        wait_drained();

        set_idle(0, 0);
        write_limit(CFG_MAX_BUNDLE, $urandom_range(1, 100000));
        write_limit(CFG_MAX_CHUNK, $urandom_range(1, 2000));
        queue_traffic(300);
        wait_drained();

        write_limit(CFG_MAX_BUNDLE, MAX_BUNDLE_RESET);
        write_limit(CFG_MAX_CHUNK, 32'(MAX_CHUNK_RESET));
        queue_traffic(300);
        wait_drained();

        $display("Covered %0d commands and %0d statuses over seven limit settings,",
                 n_commands, n_results);
        $display("both idle patterns and back-to-back flow: %0d commits, %0d staging aborts.",
                 n_commits, n_strobes);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("chunked_install_transaction_fsm test passed");
        end else begin
            $display("%0d mismatches, %0d statuses missing",
                     mismatch_count, predicted_results.size());
            $display("chunked_install_transaction_fsm test failed");
        end
        $finish;
    end

endmodule
